// ===== src/tcc_pkg.sv =====
// tcc_pkg: shared types and constants of the text console cursor engine
// no dependencies; imported by every module of the block except tcc_check
`timescale 1ns / 1ps

package tcc_pkg;

    localparam logic [2:0] OP_PUTC   = 3'd0;
    localparam logic [2:0] OP_PUTPOS = 3'd1;
    localparam logic [2:0] OP_SETCUR = 3'd2;
    localparam logic [2:0] OP_FILL   = 3'd3;
    localparam logic [2:0] OP_READ   = 3'd4;

    localparam logic [3:0] K_NOP    = 4'd0;
    localparam logic [3:0] K_NL     = 4'd1;
    localparam logic [3:0] K_CR     = 4'd2;
    localparam logic [3:0] K_BS     = 4'd3;
    localparam logic [3:0] K_CHAR   = 4'd4;
    localparam logic [3:0] K_PUTPOS = 4'd5;
    localparam logic [3:0] K_SETCUR = 4'd6;
    localparam logic [3:0] K_FILL   = 4'd7;
    localparam logic [3:0] K_READ   = 4'd8;

    localparam logic [7:0]  CH_NL      = 8'h0A;
    localparam logic [7:0]  CH_CR      = 8'h0D;
    localparam logic [7:0]  CH_BS      = 8'h08;
    localparam logic [7:0]  CH_SPACE   = 8'h20;
    localparam logic [7:0]  ATTR_BLANK = 8'h0F;
    localparam logic [15:0] BLANK_CELL = {ATTR_BLANK, CH_SPACE};

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] char_code;
        logic [7:0] attribute;
        logic [7:0] col;
        logic [7:0] row;
        logic       in_range;
    } t_cmd;

    typedef struct packed {
        logic        echo_valid;
        logic [7:0]  echo_byte;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [15:0] cell_data;
        logic        last;
    } t_result;

endpackage

// ===== src/tcc_front.sv =====
// tcc_front: input queue that classifies each transaction as it enters
// depends on tcc_pkg
`timescale 1ns / 1ps

module tcc_front import tcc_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_opcode,
    input  logic [7:0] i_char_code,
    input  logic [7:0] i_attribute,
    input  logic [7:0] i_col,
    input  logic [7:0] i_row,
    input  logic       i_pop,
    output logic       o_empty,
    output t_cmd       o_cmd
);

    localparam int DEPTH = 4;

    t_cmd       r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    t_cmd       n_entry;
    logic       push_ok, pop_ok;

    always_comb begin
        n_entry.char_code = i_char_code;
        n_entry.attribute = i_attribute;
        n_entry.col       = i_col;
        n_entry.row       = i_row;
        n_entry.in_range  = (32'(i_col) < COLUMNS) && (32'(i_row) < ROWS);
        case (i_opcode)
            OP_PUTC: begin
                if (i_char_code == CH_NL)      n_entry.kind = K_NL;
                else if (i_char_code == CH_CR) n_entry.kind = K_CR;
                else if (i_char_code == CH_BS) n_entry.kind = K_BS;
                else                           n_entry.kind = K_CHAR;
            end
            OP_PUTPOS: n_entry.kind = K_PUTPOS;
            OP_SETCUR: n_entry.kind = K_SETCUR;
            OP_FILL:   n_entry.kind = K_FILL;
            OP_READ:   n_entry.kind = K_READ;
            default:   n_entry.kind = K_NOP;
        endcase
    end

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_cmd   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= n_entry;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 2'd1;
            if (pop_ok)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push_ok) - 3'(pop_ok);
        end
    end

endmodule

// ===== src/tcc_out.sv =====
// tcc_out: result queue between the executor and the result ports
// depends on tcc_pkg
`timescale 1ns / 1ps

module tcc_out import tcc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_res
);

    localparam int DEPTH = 4;

    t_result    r_q [DEPTH];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign o_res   = r_q[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) r_q[r_wp] <= i_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) r_wp <= r_wp + 2'd1;
            if (pop_ok)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(push_ok) - 3'(pop_ok);
        end
    end

endmodule

// ===== src/tcc_back.sv =====
// tcc_back: executor with the screen store, cursor and scroll/fill sequencer
// depends on tcc_pkg; fed by tcc_front, drains into tcc_out
`timescale 1ns / 1ps

module tcc_back import tcc_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    logic [15:0] mem [CELLS];
    logic [15:0] r_rdata;

    logic [2:0]    r_state, n_state;
    logic [AW-1:0] r_cnt, n_cnt;
    logic          r_wpend, n_wpend;
    logic [AW-1:0] r_waddr, n_waddr;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [15:0]   r_fillv, n_fillv;
    logic          r_inrng, n_inrng;
    logic [7:0]    r_echo [3];
    logic [7:0]    n_echo [3];
    logic          r_evalid, n_evalid;
    logic [1:0]    r_nres, n_nres;
    logic [1:0]    r_k, n_k;
    logic [15:0]   r_cell, n_cell;

    logic          mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [15:0]   mem_wd;
    logic [RW:0]   row_inc;
    logic [8:0]    sx, sy;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_wpend  = r_wpend;
        n_waddr  = r_waddr;
        n_col    = r_col;
        n_row    = r_row;
        n_fillv  = r_fillv;
        n_inrng  = r_inrng;
        n_echo   = r_echo;
        n_evalid = r_evalid;
        n_nres   = r_nres;
        n_k      = r_k;
        n_cell   = r_cell;
        mem_we   = 1'b0;
        mem_wa   = r_cnt;
        mem_wd   = '0;
        mem_ra   = r_cnt;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        row_inc  = {1'b0, r_row} + (RW+1)'(1);
        sx       = {1'b0, i_cmd.col};
        sy       = {1'b0, i_cmd.row};

        case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt == AW'(CELLS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_k      = '0;
                    n_cell   = '0;
                    n_evalid = 1'b0;
                    n_nres   = 2'd1;
                    n_echo   = '{default: 8'h00};
                    n_cnt    = '0;
                    n_state  = S_EMIT;
                    case (i_cmd.kind)
                        K_NL: begin
                            n_col     = '0;
                            n_evalid  = 1'b1;
                            n_echo[0] = CH_NL;
                            if (32'(row_inc) >= ROWS) begin
                                n_row   = RW'(ROWS - 1);
                                n_state = S_SCROLL;
                            end else begin
                                n_row = row_inc[RW-1:0];
                            end
                        end
                        K_CR: begin
                            n_col     = '0;
                            n_evalid  = 1'b1;
                            n_echo[0] = CH_CR;
                        end
                        K_BS: begin
                            if (r_col != '0) begin
                                n_col     = r_col - CW'(1);
                                mem_we    = 1'b1;
                                mem_wa    = AW'(32'(r_row) * COLUMNS + 32'(r_col) - 1);
                                mem_wd    = BLANK_CELL;
                                n_evalid  = 1'b1;
                                n_nres    = 2'd3;
                                n_echo[0] = CH_BS;
                                n_echo[1] = CH_SPACE;
                                n_echo[2] = CH_BS;
                            end
                        end
                        K_CHAR: begin
                            mem_we    = 1'b1;
                            mem_wa    = AW'(32'(r_row) * COLUMNS + 32'(r_col));
                            mem_wd    = {i_cmd.attribute, i_cmd.char_code};
                            n_evalid  = 1'b1;
                            n_echo[0] = i_cmd.char_code;
                            if (32'(r_col) == COLUMNS - 1) begin
                                // line wrap echoes a newline too
                                n_col     = '0;
                                n_nres    = 2'd2;
                                n_echo[1] = CH_NL;
                                if (32'(row_inc) >= ROWS) begin
                                    n_row   = RW'(ROWS - 1);
                                    n_state = S_SCROLL;
                                end else begin
                                    n_row = row_inc[RW-1:0];
                                end
                            end else begin
                                n_col = r_col + CW'(1);
                            end
                        end
                        K_PUTPOS: begin
                            if (i_cmd.in_range) begin
                                mem_we = 1'b1;
                                mem_wa = AW'(32'(i_cmd.row) * COLUMNS + 32'(i_cmd.col));
                                mem_wd = {i_cmd.attribute, i_cmd.char_code};
                            end
                        end
                        K_SETCUR: begin
                            if (32'(sx) >= COLUMNS) begin
                                sx = '0;
                                sy = sy + 9'd1;
                            end
                            n_col = CW'(sx);
                            if (32'(sy) >= ROWS) begin
                                // one scroll however far below the bottom
                                n_row   = RW'(ROWS - 1);
                                n_state = S_SCROLL;
                            end else begin
                                n_row = RW'(sy);
                            end
                        end
                        K_FILL: begin
                            n_fillv = {i_cmd.attribute, i_cmd.char_code};
                            n_col   = '0;
                            n_row   = '0;
                            n_state = S_FILL;
                        end
                        K_READ: begin
                            n_inrng = i_cmd.in_range;
                            if (i_cmd.in_range)
                                mem_ra = AW'(32'(i_cmd.row) * COLUMNS + 32'(i_cmd.col));
                            n_state = S_RDWAIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_SCROLL: begin
                // read one row ahead, write the cell in the next cycle
                if (r_wpend) begin
                    mem_we = 1'b1;
                    mem_wa = r_waddr;
                    mem_wd = r_rdata;
                end
                if (r_cnt == AW'(CELLS - COLUMNS)) begin
                    n_wpend = 1'b0;
                    n_state = S_BLANK;
                end else begin
                    mem_ra  = r_cnt + AW'(COLUMNS);
                    n_wpend = 1'b1;
                    n_waddr = r_cnt;
                    n_cnt   = r_cnt + AW'(1);
                end
            end
            S_BLANK: begin
                mem_we = 1'b1;
                mem_wd = BLANK_CELL;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt == AW'(CELLS - 1)) n_state = S_EMIT;
            end
            S_FILL: begin
                mem_we = 1'b1;
                mem_wd = r_fillv;
                n_cnt  = r_cnt + AW'(1);
                if (r_cnt == AW'(CELLS - 1)) n_state = S_EMIT;
            end
            S_RDWAIT: begin
                n_cell  = r_inrng ? r_rdata : 16'h0000;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_k        = r_k + 2'd1;
                    if (r_k == r_nres - 2'd1) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.echo_valid = r_evalid;
        o_res.echo_byte  = r_evalid ? r_echo[r_k] : 8'h00;
        o_res.cursor_col = 7'(r_col);
        o_res.cursor_row = 5'(r_row);
        o_res.cell_data  = r_cell;
        o_res.last       = (r_k == r_nres - 2'd1);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_wa] <= mem_wd;
        r_rdata <= mem[mem_ra];
    end

    always_ff @(posedge i_clk) begin
        r_waddr  <= n_waddr;
        r_fillv  <= n_fillv;
        r_inrng  <= n_inrng;
        r_echo   <= n_echo;
        r_evalid <= n_evalid;
        r_nres   <= n_nres;
        r_k      <= n_k;
        r_cell   <= n_cell;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_wpend <= 1'b0;
            r_col   <= '0;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wpend <= n_wpend;
            r_col   <= n_col;
            r_row   <= n_row;
        end
    end

endmodule

// ===== src/text_console_cursor_engine.sv =====
// text_console_cursor_engine: top level of the text console cursor engine
// depends on tcc_pkg, tcc_front, tcc_back, tcc_out
`timescale 1ns / 1ps

// Commands enter a four-entry queue and are executed one at a time against a
// COLUMNS x ROWS screen store with one read port and one write port. An
// ordinary command is executed and then emits one to three results; a read
// first passes through a wait state for the registered store read. Scroll
// walks the store through its one write port, and fill writes every cell.
// After reset a clearing pass zeroes the store; transactions queue up during
// it but are executed only afterwards. Results wait in a four-entry queue.
module text_console_cursor_engine import tcc_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_opcode,
    input  logic [7:0]  i_char_code,
    input  logic [7:0]  i_attribute,
    input  logic [7:0]  i_col,
    input  logic [7:0]  i_row,
    output logic        empty,
    input  logic        pop,
    output logic        o_echo_valid,
    output logic [7:0]  o_echo_byte,
    output logic [6:0]  o_cursor_col,
    output logic [4:0]  o_cursor_row,
    output logic [15:0] o_cell_data,
    output logic        o_last
);

    t_cmd    cmd;
    logic    cmd_empty, cmd_pop;
    t_result res_in, res_out;
    logic    res_full, res_push;

    tcc_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_opcode    (i_opcode),
        .i_char_code (i_char_code),
        .i_attribute (i_attribute),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_pop       (cmd_pop),
        .o_empty     (cmd_empty),
        .o_cmd       (cmd)
    );

    tcc_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res_in)
    );

    tcc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_res   (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out)
    );

    assign o_echo_valid = res_out.echo_valid;
    assign o_echo_byte  = res_out.echo_byte;
    assign o_cursor_col = res_out.cursor_col;
    assign o_cursor_row = res_out.cursor_row;
    assign o_cell_data  = res_out.cell_data;
    assign o_last       = res_out.last;

endmodule

// ===== src/tcc_check.sv =====
// tcc_check: port-level checks on the result stream of the console engine
// bound to text_console_cursor_engine; no package dependency
`timescale 1ns / 1ps

module tcc_check #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_echo_valid,
    input logic [7:0]  o_echo_byte,
    input logic [6:0]  o_cursor_col,
    input logic [4:0]  o_cursor_row,
    input logic        o_last
);

    // results without an echo carry a zero byte
    a_no_echo_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_echo_valid |-> o_echo_byte == 8'h00)
        else $error("echo byte set without echo");

    // only echo bursts span more than one result
    a_multi_is_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !o_last |-> o_echo_valid)
        else $error("non-final result without echo");

    a_cursor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (32'(o_cursor_col) < COLUMNS) && (32'(o_cursor_row) < ROWS))
        else $error("cursor out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_echo_byte) && $stable(o_last))
        else $error("waiting result changed");

endmodule

bind text_console_cursor_engine tcc_check #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tcc_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_echo_valid (o_echo_valid),
    .o_echo_byte  (o_echo_byte),
    .o_cursor_col (o_cursor_col),
    .o_cursor_row (o_cursor_row),
    .o_last       (o_last)
);

// ===== verif/tb_text_console_cursor_engine.sv =====
// tb_text_console_cursor_engine: self-checking bench for the text console cursor engine
// depends on tcc_pkg and text_console_cursor_engine; a scoreboard class predicts every result
`timescale 1ns / 1ps

class console_scoreboard;
    localparam int COLS  = 80;
    localparam int LINES = 25;
    localparam int CELLS = COLS * LINES;

    logic [15:0] screen[CELLS];
    int unsigned crs_col;
    int unsigned crs_row;
    tcc_pkg::t_result expected_q[$];
    int mismatches;

    function new();
        foreach (screen[i]) screen[i] = '0;
        crs_col = 0;
        crs_row = 0;
        mismatches = 0;
    endfunction

    function void scroll_screen();
        for (int i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
        for (int i = CELLS - COLS; i < CELLS; i++) screen[i] = tcc_pkg::BLANK_CELL;
        crs_col = 0;
        crs_row = LINES - 1;
    endfunction

    // work out the result transactions of one accepted command
    function void note_command(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                               logic [7:0] c, logic [7:0] r);
        logic [7:0] echo_bytes[$];
        logic [15:0] cell_val;
        int unsigned x;
        int unsigned y;
        int unsigned n;
        tcc_pkg::t_result res;
        cell_val = '0;
        x = c;
        y = r;
        case (op)
            tcc_pkg::OP_PUTC: begin
                if (ch == tcc_pkg::CH_NL) begin
                    crs_col = 0;
                    crs_row++;
                    echo_bytes.push_back(tcc_pkg::CH_NL);
                end else if (ch == tcc_pkg::CH_CR) begin
                    crs_col = 0;
                    echo_bytes.push_back(tcc_pkg::CH_CR);
                end else if (ch == tcc_pkg::CH_BS) begin
                    if (crs_col > 0) begin
                        crs_col--;
                        screen[crs_row * COLS + crs_col] = tcc_pkg::BLANK_CELL;
                        echo_bytes.push_back(tcc_pkg::CH_BS);
                        echo_bytes.push_back(tcc_pkg::CH_SPACE);
                        echo_bytes.push_back(tcc_pkg::CH_BS);
                    end
                end else begin
                    screen[crs_row * COLS + crs_col] = {attr, ch};
                    echo_bytes.push_back(ch);
                    crs_col++;
                end
                if (crs_col >= COLS) begin
                    crs_col = 0;
                    crs_row++;
                    if (echo_bytes.size() < 3) echo_bytes.push_back(tcc_pkg::CH_NL);
                end
                if (crs_row >= LINES) scroll_screen();
            end
            tcc_pkg::OP_PUTPOS: begin
                if (x < COLS && y < LINES) screen[y * COLS + x] = {attr, ch};
            end
            tcc_pkg::OP_SETCUR: begin
                if (x >= COLS) begin
                    x = 0;
                    y++;
                end
                if (y >= LINES) begin
                    scroll_screen();
                    y = LINES - 1;
                end
                crs_col = x;
                crs_row = y;
            end
            tcc_pkg::OP_FILL: begin
                foreach (screen[i]) screen[i] = {attr, ch};
                crs_col = 0;
                crs_row = 0;
            end
            tcc_pkg::OP_READ: begin
                if (x < COLS && y < LINES) cell_val = screen[y * COLS + x];
            end
            default: ;
        endcase
        n = (echo_bytes.size() > 0) ? echo_bytes.size() : 1;
        for (int k = 0; k < n; k++) begin
            res.echo_valid = echo_bytes.size() > 0;
            res.echo_byte  = (echo_bytes.size() > 0) ? echo_bytes[k] : 8'h00;
            res.cursor_col = crs_col[6:0];
            res.cursor_row = crs_row[4:0];
            res.cell_data  = cell_val;
            res.last       = (k == n - 1);
            expected_q.push_back(res);
        end
    endfunction

    function void check_result(tcc_pkg::t_result got);
        tcc_pkg::t_result exp_res;
        if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transaction: %p", got);
            return;
        end
        exp_res = expected_q.pop_front();
        if (got.echo_valid !== exp_res.echo_valid || got.echo_byte !== exp_res.echo_byte ||
            got.cursor_col !== exp_res.cursor_col || got.cursor_row !== exp_res.cursor_row ||
            got.cell_data !== exp_res.cell_data || got.last !== exp_res.last) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result mismatch: expected %p, actual %p", exp_res, got);
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_text_console_cursor_engine;
    import tcc_pkg::*;

    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic [2:0]  i_opcode = '0;
    logic [7:0]  i_char_code = '0;
    logic [7:0]  i_attribute = '0;
    logic [7:0]  i_col = '0;
    logic [7:0]  i_row = '0;
    logic        full;
    logic        empty;
    logic        o_echo_valid;
    logic [7:0]  o_echo_byte;
    logic [6:0]  o_cursor_col;
    logic [4:0]  o_cursor_row;
    logic [15:0] o_cell_data;
    logic        o_last;

    console_scoreboard sb = new();
    bit idle_on = 1'b1;
    int stall_left = 0;

    text_console_cursor_engine u_dut (
        .i_clk, .i_rst_n, .push, .full, .i_opcode, .i_char_code, .i_attribute,
        .i_col, .i_row, .empty, .pop, .o_echo_valid, .o_echo_byte, .o_cursor_col,
        .o_cursor_row, .o_cell_data, .o_last
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    task automatic send_cmd(logic [2:0] op, logic [7:0] ch, logic [7:0] attr,
                            logic [7:0] c, logic [7:0] r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        push        <= 1'b1;
        i_opcode    <= op;
        i_char_code <= ch;
        i_attribute <= attr;
        i_col       <= c;
        i_row       <= r;
        do @(posedge i_clk); while (full);
        sb.note_command(op, ch, attr, c, r);
    endtask

    task automatic send_random();
        int unsigned pick;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        ch = 8'($urandom);
        if ($urandom_range(0, 5) == 0) begin
            case ($urandom_range(0, 2))
                0: ch = CH_NL;
                1: ch = CH_CR;
                default: ch = CH_BS;
            endcase
        end
        if (pick < 50)
            send_cmd(OP_PUTC, ch, 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 62)
            send_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 85)),
                     8'($urandom_range(0, 27)));
        else if (pick < 74)
            send_cmd(OP_PUTPOS, 8'($urandom), 8'($urandom), 8'($urandom_range(0, 85)),
                     8'($urandom_range(0, 27)));
        else if (pick < 88)
            // land mostly near the right edge and bottom row so wraps and scrolls occur
            send_cmd(OP_SETCUR, 8'($urandom), 8'($urandom), 8'($urandom_range(70, 81)),
                     8'($urandom_range(20, 25)));
        else if (pick < 93)
            send_cmd(OP_SETCUR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 95)
            send_cmd(OP_FILL, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        else
            send_cmd(3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), 8'($urandom),
                     8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    // result side: check at each accepting edge, then choose pop for the next cycle
    initial begin
        tcc_pkg::t_result got;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                got = '{o_echo_valid, o_echo_byte, o_cursor_col, o_cursor_row,
                        o_cell_data, o_last};
                sb.check_result(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                pop <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 13);
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    initial begin
        int guard;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reads of the cleared store, extremes, specials, wrap, scroll, fill and spare opcodes
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd79, 8'd24);
        send_cmd(OP_PUTC, 8'h00, 8'hFF, 8'd0, 8'd0);
        send_cmd(OP_PUTC, 8'hFF, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_PUTC, CH_BS, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_PUTC, CH_CR, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_PUTC, CH_BS, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_PUTC, CH_NL, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd1, 8'd0);
        send_cmd(OP_PUTPOS, 8'hA5, 8'h5A, 8'd79, 8'd24);
        send_cmd(OP_PUTPOS, 8'h11, 8'h22, 8'd80, 8'd0);
        send_cmd(OP_PUTPOS, 8'h11, 8'h22, 8'd0, 8'd255);
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd255, 8'd255);
        send_cmd(OP_SETCUR, 8'h00, 8'h00, 8'd79, 8'd3);
        send_cmd(OP_PUTC, 8'h41, 8'h07, 8'd0, 8'd0);
        send_cmd(OP_SETCUR, 8'h00, 8'h00, 8'd80, 8'd24);
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd79, 8'd23);
        send_cmd(OP_SETCUR, 8'h00, 8'h00, 8'd200, 8'd255);
        send_cmd(OP_PUTC, CH_NL, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_FILL, 8'h7E, 8'h81, 8'd255, 8'd255);
        send_cmd(OP_READ, 8'h00, 8'h00, 8'd40, 8'd12);
        send_cmd(OP_SPARE_LO, 8'hFF, 8'hFF, 8'd255, 8'd255);
        send_cmd(OP_SPARE_MID, 8'h00, 8'h00, 8'd0, 8'd0);
        send_cmd(OP_SPARE_HI, 8'h55, 8'hAA, 8'd1, 8'd2);

        for (int i = 0; i < 180; i++) begin
            if (i == 140) idle_on = 1'b0;
            send_random();
        end
        push <= 1'b0;

        guard = 0;
        while (sb.pending() > 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
